@@ rtl/assert_macros.svh @@
// assertion macros used by the allocator rtl
// each macro takes a label, a property or condition and a message string
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PSA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PSA_ASSERT(lbl, prop, msg)
`define PSA_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ rtl/psa_pkg.sv @@
// ----------------------------------------------------------------------------
// psa_pkg
// request and result types and fixed field widths of the slot allocator
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int SLOT_W    = 13;
  localparam int CNT_W     = 11;
  localparam int PART_W    = 3;
  localparam int OFF_W     = 10;
  localparam int WORD_BITS = 16;
  localparam int WBW       = 4;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_FIND  = 2'd2,
    CMD_COUNT = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [PART_W-1:0] partition;
    logic [SLOT_W-1:0] global_slot;
    logic [OFF_W-1:0]  start_offset;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic              ok;
    logic [CNT_W-1:0]  occupied_count;
  } res_t;

endpackage

@@ rtl/partitioned_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// partitioned_slot_allocator
// path per request: count goes through S_LOAD; free through S_DIV (quotient, then
//   remainder), a word read and S_FREE; allocate through S_LOAD and S_SCAN; find
//   through S_DIV and S_SCAN; an out-of-range request is answered from S_IDLE
// throughput: one request at a time; the scan reads one 16-bit bitmap word a cycle,
//   WPP = SLOTS_PER_PART/16 words of the bitmap per partition (64 here), and the
//   next request can be taken at the edge that takes the result
// reset: bitmap memory is swept to zero over all PARTITIONS*WPP words (512 here),
//   busy stays high during the sweep; pointers and counts clear at once
`include "assert_macros.svh"

module partitioned_slot_allocator
  import psa_pkg::*;
#(
  parameter int PARTITIONS     = 8,
  parameter int SLOTS_PER_PART = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic valid_o,
  output res_t res_o
);

  // derived sizes
  localparam int PW    = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int OW    = $clog2(SLOTS_PER_PART);
  localparam int CW    = $clog2(SLOTS_PER_PART + 1);
  localparam int WPP   = (SLOTS_PER_PART + WORD_BITS - 1) / WORD_BITS;
  localparam int NW    = PARTITIONS * WPP;
  localparam int AW    = (NW > 1) ? $clog2(NW) : 1;
  localparam int WIW   = (WPP > 1) ? $clog2(WPP) : 1;
  localparam int VW    = $clog2(WPP + 2);
  localparam int TOTAL = PARTITIONS * SLOTS_PER_PART;
  localparam int LAST_BITS = SLOTS_PER_PART - (WPP - 1) * WORD_BITS;
  localparam logic [WORD_BITS:0] LAST_ONE = (WORD_BITS + 1)'(1) << LAST_BITS;
  localparam logic [WORD_BITS-1:0] LAST_MASK = WORD_BITS'(LAST_ONE - 1'b1);

  // reciprocal of the partition size: quotient = (n * DIV_M) >> DIV_S,
  // exact for every SLOT_W-bit numerator
  localparam int MW    = SLOT_W + 2;
  localparam int DIV_S = SLOT_W + OW;
  localparam logic [63:0] DIV_M =
    ((64'd1 << DIV_S) + 64'(SLOTS_PER_PART) - 64'd1) / 64'(SLOTS_PER_PART);
  localparam logic [SLOT_W-1:0] SPP_S = SLOT_W'(SLOTS_PER_PART);

  // controller states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FREE  = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;

  // bitmap word address of partition p, word w within it
  function automatic logic [AW-1:0] word_addr(logic [PW-1:0] p, logic [WIW-1:0] w);
    return AW'(int'(p) * WPP + int'(w));
  endfunction

  // absolute slot number, cut to the result field width
  function automatic logic [SLOT_W-1:0] abs_slot(logic [PW-1:0] p, logic [OW-1:0] o);
    return SLOT_W'(int'(p) * SLOTS_PER_PART + int'(o));
  endfunction

  // occupancy bitmap, 16 slots per word
  logic [WORD_BITS-1:0] occ_mem [NW];
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] rdata_q;

  // per-partition next-fit pointer and running count
  logic [OW-1:0] ptr_q [PARTITIONS];
  logic [OW-1:0] ptr_d [PARTITIONS];
  logic [CW-1:0] cnt_q [PARTITIONS];
  logic [CW-1:0] cnt_d [PARTITIONS];

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  req_t          req_q, req_d;
  logic [PW-1:0] part_q, part_d;
  logic [OW-1:0] s_q, s_d;           // scan start or free offset

  // division by SLOTS_PER_PART in two steps: quotient, then remainder
  logic [SLOT_W-1:0]    div_n_q, div_n_d;
  logic [SLOT_W-1:0]    div_qt_q, div_qt_d;
  logic                 div_ph_q, div_ph_d;
  logic [SLOT_W+MW-1:0] div_prod;
  logic [SLOT_W-1:0]    div_back;
  logic [OW-1:0]        div_rem;

  // scan pipeline: issue side and check side
  logic [VW-1:0]        iv_q, iv_d;
  logic [WIW-1:0]       iw_q, iw_d;
  logic                 chk_vld_q, chk_vld_d;
  logic [VW-1:0]        chk_v_q, chk_v_d;
  logic [WIW-1:0]       chk_w_q, chk_w_d;
  logic [WORD_BITS-1:0] first_q, first_d;

  logic                 valid_q, valid_d;
  res_t                 res_q, res_d;

  // derived views
  logic [WIW-1:0]       s_widx;
  logic [WBW-1:0]       s_bit;
  logic [CW-1:0]        cnt_cur;
  logic [OW-1:0]        ptr_cur;
  logic                 is_alloc;
  logic [WORD_BITS-1:0] rng, cand;
  logic [WBW-1:0]       lsb;
  logic                 scan_hit, scan_miss;
  logic [OW-1:0]        hit_off;

  assign s_widx   = WIW'(s_q / WORD_BITS);
  assign s_bit    = WBW'(s_q % WORD_BITS);
  assign cnt_cur  = cnt_q[part_q];
  assign ptr_cur  = ptr_q[part_q];
  assign is_alloc = (req_q.command == CMD_ALLOC);

  assign div_prod = (SLOT_W + MW)'(div_n_q) * (SLOT_W + MW)'(DIV_M);
  assign div_back = div_qt_q * SPP_S;
  assign div_rem  = OW'(div_n_q - div_back);

  // candidate bits of the word under check: range of this visit, then
  // free bits for allocate (pointer slot excluded) or occupied bits for find
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      rng[j] = 1'b1;
      if (chk_w_q == WIW'(WPP - 1) && !LAST_MASK[j]) rng[j] = 1'b0;
      if (chk_v_q == '0 && (WBW'(j) < s_bit || (is_alloc && WBW'(j) == s_bit))) begin
        rng[j] = 1'b0;
      end
      if (chk_v_q == VW'(WPP) && WBW'(j) >= s_bit) rng[j] = 1'b0;
    end
    cand = (is_alloc ? ~rdata_q : rdata_q) & rng;
    lsb = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) lsb = WBW'(j);
    end
  end

  assign scan_hit  = chk_vld_q && (|cand);
  assign scan_miss = chk_vld_q && !(|cand) && (chk_v_q == VW'(WPP));
  assign hit_off   = OW'(int'(chk_w_q) * WORD_BITS + int'(lsb));

  // main controller
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    req_d     = req_q;
    part_d    = part_q;
    s_d       = s_q;
    div_n_d   = div_n_q;
    div_qt_d  = div_qt_q;
    div_ph_d  = div_ph_q;
    iv_d      = iv_q;
    iw_d      = iw_q;
    chk_vld_d = 1'b0;
    chk_v_d   = chk_v_q;
    chk_w_d   = chk_w_q;
    first_d   = first_q;
    ptr_d     = ptr_q;
    cnt_d     = cnt_q;
    valid_d   = 1'b0;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;

    case (state_q)
      S_CLEAR: begin
        // sweep the bitmap to all free after reset
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(NW - 1)) state_d = S_IDLE;
      end

      S_IDLE: begin
        if (start) begin
          req_d  = req_i;
          part_d = PW'(req_i.partition);
          case (req_i.command)
            CMD_FREE: begin
              if (int'(req_i.global_slot) >= TOTAL) begin
                valid_d = 1'b1;
                res_d   = '0;
              end else begin
                div_n_d  = req_i.global_slot;
                div_ph_d = 1'b0;
                state_d  = S_DIV;
              end
            end
            CMD_FIND: begin
              if (int'(req_i.partition) >= PARTITIONS) begin
                valid_d = 1'b1;
                res_d   = '0;
              end else begin
                // start offset reduced modulo the partition size
                div_n_d  = SLOT_W'(req_i.start_offset);
                div_ph_d = 1'b0;
                state_d  = S_DIV;
              end
            end
            default: begin
              if (int'(req_i.partition) >= PARTITIONS) begin
                valid_d = 1'b1;
                res_d   = '0;
              end else begin
                state_d = S_LOAD;
              end
            end
          endcase
        end
      end

      S_LOAD: begin
        if (req_q.command == CMD_COUNT) begin
          valid_d              = 1'b1;
          res_d.slot_out       = '0;
          res_d.ok             = 1'b1;
          res_d.occupied_count = CNT_W'(cnt_cur);
          state_d              = S_IDLE;
        end else begin
          // allocate scans from the pointer slot
          s_d     = ptr_cur;
          iw_d    = WIW'(ptr_cur / WORD_BITS);
          iv_d    = '0;
          state_d = S_SCAN;
        end
      end

      S_DIV: begin
        if (!div_ph_q) begin
          // quotient first, remainder from it in the next cycle
          div_qt_d = SLOT_W'(div_prod >> DIV_S);
          div_ph_d = 1'b1;
        end else begin
          s_d = div_rem;
          if (req_q.command == CMD_FREE) begin
            part_d    = PW'(div_qt_q);
            mem_re    = 1'b1;
            mem_raddr = word_addr(PW'(div_qt_q), WIW'(div_rem / WORD_BITS));
            state_d   = S_FREE;
          end else begin
            iw_d    = WIW'(div_rem / WORD_BITS);
            iv_d    = '0;
            state_d = S_SCAN;
          end
        end
      end

      S_FREE: begin
        valid_d        = 1'b1;
        res_d.slot_out = req_q.global_slot;
        state_d        = S_IDLE;
        if (rdata_q[s_bit]) begin
          mem_we    = 1'b1;
          mem_waddr = word_addr(part_q, s_widx);
          mem_wdata = rdata_q & ~(WORD_BITS'(1) << s_bit);
          if (cnt_cur != '0) begin
            cnt_d[part_q]        = cnt_cur - 1'b1;
            res_d.occupied_count = CNT_W'(cnt_cur - 1'b1);
          end else begin
            res_d.occupied_count = CNT_W'(cnt_cur);
          end
          res_d.ok = 1'b1;
        end else begin
          res_d.ok             = 1'b0;
          res_d.occupied_count = CNT_W'(cnt_cur);
        end
      end

      S_SCAN: begin
        if (chk_vld_q && chk_v_q == '0) first_d = rdata_q;
        if (scan_hit) begin
          valid_d = 1'b1;
          state_d = S_IDLE;
          res_d.ok = 1'b1;
          if (is_alloc) begin
            // mark the pointer slot taken, pointer moves to the slot found
            mem_we    = 1'b1;
            mem_waddr = word_addr(part_q, s_widx);
            mem_wdata = ((chk_v_q == '0) ? rdata_q : first_q) | (WORD_BITS'(1) << s_bit);
            ptr_d[part_q] = hit_off;
            if (cnt_cur < CW'(SLOTS_PER_PART)) begin
              cnt_d[part_q]        = cnt_cur + 1'b1;
              res_d.occupied_count = CNT_W'(cnt_cur + 1'b1);
            end else begin
              res_d.occupied_count = CNT_W'(cnt_cur);
            end
            res_d.slot_out = abs_slot(part_q, s_q);
          end else begin
            res_d.slot_out       = abs_slot(part_q, hit_off);
            res_d.occupied_count = CNT_W'(cnt_cur);
          end
        end else if (scan_miss) begin
          valid_d              = 1'b1;
          state_d              = S_IDLE;
          res_d.slot_out       = '0;
          res_d.ok             = 1'b0;
          res_d.occupied_count = CNT_W'(cnt_cur);
        end else if (iv_q <= VW'(WPP)) begin
          // one word read per cycle, wrapping inside the partition
          mem_re    = 1'b1;
          mem_raddr = word_addr(part_q, iw_q);
          chk_vld_d = 1'b1;
          chk_v_d   = iv_q;
          chk_w_d   = iw_q;
          iv_d      = iv_q + 1'b1;
          iw_d      = (iw_q == WIW'(WPP - 1)) ? '0 : iw_q + 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // bitmap memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) occ_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rdata_q <= occ_mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      part_q    <= '0;
      chk_vld_q <= 1'b0;
      valid_q   <= 1'b0;
      ptr_q     <= '{default: '0};
      cnt_q     <= '{default: '0};
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      part_q    <= part_d;
      chk_vld_q <= chk_vld_d;
      valid_q   <= valid_d;
      ptr_q     <= ptr_d;
      cnt_q     <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    s_q       <= s_d;
    div_n_q   <= div_n_d;
    div_qt_q  <= div_qt_d;
    div_ph_q  <= div_ph_d;
    iv_q      <= iv_d;
    iw_q      <= iw_d;
    chk_v_q   <= chk_v_d;
    chk_w_q   <= chk_w_d;
    first_q   <= first_d;
    res_q     <= res_d;
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  // checks
  `PSA_ASSERT(a_res_idle, valid_q |-> (state_q == S_IDLE), "result while request in flight")
  `PSA_ASSERT(a_wr_then_idle, (mem_we && state_q != S_CLEAR) |=> !mem_re, "read right after write back")
  `PSA_ASSERT_NEVER(a_rw_same, mem_we && mem_re && (mem_waddr == mem_raddr), "read and write same word")
  `PSA_ASSERT(a_cnt_max, cnt_cur <= CW'(SLOTS_PER_PART), "partition count above size")
  `PSA_ASSERT(a_chk_range, chk_vld_q |-> (chk_v_q <= VW'(WPP)), "scan ran past last visit")

endmodule
